@@ hdl/index_register_control_unit_top_assert.svh @@
// Assertion macros for the index register control unit.
// Used by index_register_control_unit_top; needs no other file.
`ifndef INDEX_REGISTER_CONTROL_UNIT_TOP_ASSERT_SVH
`define INDEX_REGISTER_CONTROL_UNIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define IRCU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("index register control unit assertion failed");
`define IRCU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("index register control unit assertion failed");
`else
`define IRCU_ASSERT_NOW(label, clk, rstn, ante, cons)
`define IRCU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/ircu_pkg.sv @@
// Shared types and constants of the index register control unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ircu_pkg;

    localparam int NUM_INDEX_REGS = 4;
    localparam int SEL_W          = 2;
    localparam int DATA_W         = 32;
    localparam int RANGE_W        = 10;
    localparam int CMD_W          = 3;
    localparam int CFG_INDEX_W    = 3;
    localparam int FRAC_W         = 16;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MODULO = 3'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_X_RANGE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_RANGE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_U_RANGE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_V_RANGE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER0_LOAD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER1_LOAD = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ADD    = 3'd1,
        OP_MOVE   = 3'd2,
        OP_CHECK  = 3'd3,
        OP_MODULO = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] operand;
        logic              dec0;
        logic              dec1;
    } item_t;

endpackage
`default_nettype wire

@@ hdl/index_register_control_unit_top.sv @@
// Index register control unit: four 16.16 index registers with add, move,
// range check and modulo wrap, plus two loop counters that count down to zero.
// Usage:
//   Items arrive on the s_ channel and each produces one result transfer on the
//   m_ channel, in order. Configuration writes arrive on the cfg_ channel
//   (index 0 to 3 set the x, y, u, v ranges, 4 and 5 load the counters) and
//   are always accepted; they must only be issued while the block is idle.
//   An input transfer is held in the front queue and then executed in the
//   execute stage, which fills the result register that drives m_valid.
//   Throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds, the two-entry queue
//   fills, and s_ready drops once both entries are occupied.
//   Synchronous active-low reset clears all index registers, ranges, counters
//   and flags at once and empties the queue; no clearing pass follows.
// Depends on ircu_pkg, ircu_front, ircu_queue, ircu_back and the assertion
// macro header.
`default_nettype none
`include "index_register_control_unit_top_assert.svh"
module index_register_control_unit_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ircu_pkg::CMD_W-1:0]          s_command,
    input  wire logic [ircu_pkg::SEL_W-1:0]          s_index_select,
    input  wire logic [ircu_pkg::DATA_W-1:0]         s_operand_value,
    input  wire logic                                s_dec_counter0,
    input  wire logic                                s_dec_counter1,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ircu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ircu_pkg::DATA_W-1:0]         cfg_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ircu_pkg::DATA_W-1:0]              m_index_value,
    output logic [ircu_pkg::DATA_W-1:0]              m_counter0_value,
    output logic [ircu_pkg::DATA_W-1:0]              m_counter1_value,
    output logic                                     m_counter0_zero,
    output logic                                     m_counter1_zero,
    output logic                                     m_mod_ge,
    output logic                                     m_mod_mi
);

    logic            push_valid, push_ready, pop_valid, pop_ready;
    ircu_pkg::item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    ircu_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_index_select  (s_index_select),
        .s_operand_value (s_operand_value),
        .s_dec_counter0  (s_dec_counter0),
        .s_dec_counter1  (s_dec_counter1),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    ircu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ircu_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_index_value    (m_index_value),
        .m_counter0_value (m_counter0_value),
        .m_counter1_value (m_counter1_value),
        .m_counter0_zero  (m_counter0_zero),
        .m_counter1_zero  (m_counter1_zero),
        .m_mod_ge         (m_mod_ge),
        .m_mod_mi         (m_mod_mi)
    );

    `IRCU_ASSERT_NEXT(a_pop_loads_result, aclk, aresetn, pop_valid && pop_ready, m_valid)
    `IRCU_ASSERT_NOW(a_full_queue_nonempty, aclk, aresetn, !s_ready, pop_valid)
    `IRCU_ASSERT_NOW(a_no_pop_when_stalled, aclk, aresetn, m_valid && !m_ready, !pop_ready)
    `IRCU_ASSERT_NOW(a_mod_flags_exclusive, aclk, aresetn, m_valid, !(m_mod_ge && m_mod_mi))

endmodule
`default_nettype wire

@@ hdl/ircu_front.sv @@
// Front part: accepts input transfers and classifies the command.
// Depends on ircu_pkg.
`default_nettype none
module ircu_front (
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ircu_pkg::CMD_W-1:0]      s_command,
    input  wire logic [ircu_pkg::SEL_W-1:0]      s_index_select,
    input  wire logic [ircu_pkg::DATA_W-1:0]     s_operand_value,
    input  wire logic                            s_dec_counter0,
    input  wire logic                            s_dec_counter1,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output ircu_pkg::item_t                      push_item
);

    ircu_pkg::op_t op;

    always_comb begin
        case (s_command)
            ircu_pkg::CMD_ADD:    op = ircu_pkg::OP_ADD;
            ircu_pkg::CMD_MOVE:   op = ircu_pkg::OP_MOVE;
            ircu_pkg::CMD_CHECK:  op = ircu_pkg::OP_CHECK;
            ircu_pkg::CMD_MODULO: op = ircu_pkg::OP_MODULO;
            default:              op = ircu_pkg::OP_NONE;
        endcase
    end

    assign push_item.op      = op;
    assign push_item.sel     = s_index_select;
    assign push_item.operand = s_operand_value;
    assign push_item.dec0    = s_dec_counter0;
    assign push_item.dec1    = s_dec_counter1;
    assign push_valid        = s_valid;
    assign s_ready           = push_ready;

endmodule
`default_nettype wire

@@ hdl/ircu_queue.sv @@
// Two-entry queue between the front and back parts.
// Depends on ircu_pkg.
`default_nettype none
module ircu_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  ircu_pkg::item_t push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output ircu_pkg::item_t pop_item
);

    ircu_pkg::item_t entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ircu_back.sv @@
// Back part: executes queued items on the index registers, counters and flags,
// takes configuration writes and holds the result register. Depends on ircu_pkg.
`default_nettype none
module ircu_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               pop_valid,
    output logic                                    pop_ready,
    input  ircu_pkg::item_t                         pop_item,
    input  wire logic                               cfg_write,
    input  wire logic [ircu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ircu_pkg::DATA_W-1:0]        cfg_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ircu_pkg::DATA_W-1:0]             m_index_value,
    output logic [ircu_pkg::DATA_W-1:0]             m_counter0_value,
    output logic [ircu_pkg::DATA_W-1:0]             m_counter1_value,
    output logic                                    m_counter0_zero,
    output logic                                    m_counter1_zero,
    output logic                                    m_mod_ge,
    output logic                                    m_mod_mi
);

    localparam int DW = ircu_pkg::DATA_W;

    logic [DW-1:0]                   index_reg [ircu_pkg::NUM_INDEX_REGS];
    logic [ircu_pkg::RANGE_W-1:0]    range_reg [ircu_pkg::NUM_INDEX_REGS];
    logic [DW-1:0]                   cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    logic                            z0_reg, z0_next, z1_reg, z1_next;
    logic                            ge_reg, ge_next, mi_reg, mi_next;
    logic                            out_valid_reg;
    logic [DW-1:0]                   out_index_reg, out_cnt0_reg, out_cnt1_reg;
    logic                            out_z0_reg, out_z1_reg, out_ge_reg, out_mi_reg;

    logic [DW-1:0] cur, rng, upper, wrapped, index_next;
    logic          at_or_above, pop;

    assign pop_ready = !out_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        cur         = index_reg[pop_item.sel];
        rng         = {{(DW - ircu_pkg::RANGE_W - ircu_pkg::FRAC_W){1'b0}},
                       range_reg[pop_item.sel], {ircu_pkg::FRAC_W{1'b0}}};
        upper       = {cur[DW-1:ircu_pkg::FRAC_W], {ircu_pkg::FRAC_W{1'b0}}};
        at_or_above = ($signed(upper) >= $signed(rng));
        if (at_or_above) begin
            wrapped = cur - rng;
        end else if (cur[DW-1]) begin
            wrapped = cur + rng;
        end else begin
            wrapped = cur;
        end

        index_next = cur;
        ge_next    = ge_reg;
        mi_next    = mi_reg;
        case (pop_item.op)
            ircu_pkg::OP_ADD: begin
                index_next = cur + pop_item.operand;
            end
            ircu_pkg::OP_MOVE: begin
                index_next = pop_item.operand;
            end
            ircu_pkg::OP_CHECK: begin
                ge_next = at_or_above;
                mi_next = !at_or_above && cur[DW-1];
            end
            ircu_pkg::OP_MODULO: begin
                index_next = wrapped;
                ge_next    = at_or_above;
                mi_next    = !at_or_above && cur[DW-1];
            end
            default: begin
                index_next = cur;
            end
        endcase

        cnt0_next = cnt0_reg;
        z0_next   = z0_reg;
        if (pop_item.dec0) begin
            z0_next   = (cnt0_reg[DW-1:1] == '0);
            cnt0_next = (cnt0_reg == '0) ? cnt0_reg : cnt0_reg - DW'(1);
        end
        cnt1_next = cnt1_reg;
        z1_next   = z1_reg;
        if (pop_item.dec1) begin
            z1_next   = (cnt1_reg[DW-1:1] == '0);
            cnt1_next = (cnt1_reg == '0) ? cnt1_reg : cnt1_reg - DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ircu_pkg::NUM_INDEX_REGS; i++) begin
                index_reg[i] <= '0;
                range_reg[i] <= '0;
            end
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            z0_reg        <= 1'b0;
            z1_reg        <= 1'b0;
            ge_reg        <= 1'b0;
            mi_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                index_reg[pop_item.sel] <= index_next;
                cnt0_reg      <= cnt0_next;
                cnt1_reg      <= cnt1_next;
                z0_reg        <= z0_next;
                z1_reg        <= z1_next;
                ge_reg        <= ge_next;
                mi_reg        <= mi_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                case (cfg_index)
                    ircu_pkg::REG_X_RANGE: range_reg[0] <= cfg_data[ircu_pkg::RANGE_W-1:0];
                    ircu_pkg::REG_Y_RANGE: range_reg[1] <= cfg_data[ircu_pkg::RANGE_W-1:0];
                    ircu_pkg::REG_U_RANGE: range_reg[2] <= cfg_data[ircu_pkg::RANGE_W-1:0];
                    ircu_pkg::REG_V_RANGE: range_reg[3] <= cfg_data[ircu_pkg::RANGE_W-1:0];
                    ircu_pkg::REG_COUNTER0_LOAD: cnt0_reg <= cfg_data;
                    ircu_pkg::REG_COUNTER1_LOAD: cnt1_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_index_reg <= index_next;
            out_cnt0_reg  <= cnt0_next;
            out_cnt1_reg  <= cnt1_next;
            out_z0_reg    <= z0_next;
            out_z1_reg    <= z1_next;
            out_ge_reg    <= ge_next;
            out_mi_reg    <= mi_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_index_value    = out_index_reg;
    assign m_counter0_value = out_cnt0_reg;
    assign m_counter1_value = out_cnt1_reg;
    assign m_counter0_zero  = out_z0_reg;
    assign m_counter1_zero  = out_z1_reg;
    assign m_mod_ge         = out_ge_reg;
    assign m_mod_mi         = out_mi_reg;

endmodule
`default_nettype wire
